/* rtl/iecm_pkg.sv */
package iecm_pkg;

	// default number of fraction bits of the level input
	localparam int LEVEL_FRAC_BITS_DEF = 8;

	// register reset values
	localparam logic [7:0] DISPLAY_WIDTH_RST = 8'd79;
	localparam logic [7:0] HOLD_LIMIT_RST    = 8'd12;

	// register byte addresses
	localparam logic [2:0] ADDR_DISPLAY_WIDTH = 3'd0;
	localparam logic [2:0] ADDR_HOLD_LIMIT    = 3'd4;

	// hold counter saturates here
	localparam logic [8:0] COUNTER_MAX = 9'd511;

	// scaled deflection before the final divide by 25 stays below 2^13
	localparam int QW = 13;

	// floor(q / 25) as (q * RECIP_25) >> RECIP_SH, exact for q < 2^13
	localparam int          RECIP_SH = 20;
	localparam logic [15:0] RECIP_25 = 16'd41944;

	typedef enum logic [2:0] {
		ST_IDLE,
		ST_SEG,
		ST_SCALE,
		ST_RECIP,
		ST_UPD
	} state_t;

endpackage

/* rtl/iec_meter_scale_peak_hold.sv */
// IEC 60268-18 meter scale with peak hold. Each accepted level (signed, LEVEL_FRAC_BITS
// fraction bits) is mapped through the six-slope deflection curve, scaled by
// display_width and truncated to a bar length; the peak marker jumps to a longer bar and
// otherwise drops to the bar once the hold counter has passed hold_limit. Each level goes
// through the states in turn: one shared multiplier is used three times (curve slope, width
// scaling, divide by 25 through a reciprocal), then the update state updates the peak hold
// and the sequencer returns to idle. in_ready is high only while the sequencer is idle, so
// a new level is taken only after the last one is through; a finished result waits in the
// output register, and the update state stalls while it is not taken.
module iec_meter_scale_peak_hold #(
	parameter int LEVEL_FRAC_BITS = iecm_pkg::LEVEL_FRAC_BITS_DEF
) (
	input  logic               clk,
	input  logic               arst_n,
	input  logic               in_valid,
	output logic               in_ready,
	input  logic signed [15:0] level_db,
	output logic               out_valid,
	input  logic               out_ready,
	output logic        [7:0]  bar_length,
	output logic        [7:0]  peak_marker,
	input  logic               psel,
	input  logic               penable,
	input  logic               pwrite,
	input  logic        [2:0]  paddr,
	input  logic        [31:0] pwdata,
	output logic        [31:0] prdata,
	output logic               pready
);

	localparam int F      = LEVEL_FRAC_BITS;
	localparam int S      = 1 << F;
	// compare width: holds the input and +-70 dB
	localparam int CW     = (F + 10 > 17) ? F + 10 : 17;
	// deflection width: up to 400 * 2^F
	localparam int DEF_W  = F + 9;
	// segment offset width: below 20 dB
	localparam int DW     = F + 5;
	localparam int PW     = DEF_W + 16;

	localparam logic signed [CW-1:0] T70 = CW'(-70 * S);
	localparam logic signed [CW-1:0] T60 = CW'(-60 * S);
	localparam logic signed [CW-1:0] T50 = CW'(-50 * S);
	localparam logic signed [CW-1:0] T40 = CW'(-40 * S);
	localparam logic signed [CW-1:0] T30 = CW'(-30 * S);
	localparam logic signed [CW-1:0] T20 = CW'(-20 * S);
	localparam logic signed [CW-1:0] P70 = CW'(70 * S);
	localparam logic signed [CW-1:0] P60 = CW'(60 * S);
	localparam logic signed [CW-1:0] P50 = CW'(50 * S);
	localparam logic signed [CW-1:0] P40 = CW'(40 * S);
	localparam logic signed [CW-1:0] P30 = CW'(30 * S);
	localparam logic signed [CW-1:0] P20 = CW'(20 * S);

	iecm_pkg::state_t state_q, state_d;

	logic [7:0]             display_width_q;
	logic [7:0]             hold_limit_q;
	logic signed [15:0]     lvl_q;
	logic [DEF_W-1:0]       def_q;
	logic [iecm_pkg::QW-1:0] scaled_q;
	logic [7:0]             bar_q;
	logic [7:0]             bar_length_q;
	logic [7:0]             held_peak_q;
	logic [8:0]             hold_counter_q;
	logic                   out_valid_q;

	logic signed [CW-1:0]   lvl_ext;
	logic [DW-1:0]          seg_diff;
	logic [3:0]             seg_slope;
	logic [DEF_W-1:0]       seg_base;

	logic [DEF_W-1:0]       mul_a;
	logic [15:0]            mul_b;
	logic [PW-1:0]          prod;

	logic                   cfg_wr;
	logic                   commit;

	assign cfg_wr = psel && penable && pwrite;
	assign pready = 1'b1;

	always_comb begin
		unique case (paddr)
			iecm_pkg::ADDR_DISPLAY_WIDTH: prdata = {24'd0, display_width_q};
			iecm_pkg::ADDR_HOLD_LIMIT:    prdata = {24'd0, hold_limit_q};
			default:                      prdata = 32'd0;
		endcase
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			display_width_q <= iecm_pkg::DISPLAY_WIDTH_RST;
			hold_limit_q    <= iecm_pkg::HOLD_LIMIT_RST;
		end else if (cfg_wr) begin
			if (paddr[2]) begin
				hold_limit_q <= pwdata[7:0];
			end else begin
				display_width_q <= pwdata[7:0];
			end
		end
	end

	// curve segment: offset into the segment, slope and base deflection
	assign lvl_ext = CW'(lvl_q);

	always_comb begin
		priority if (lvl_ext < T70) begin
			seg_diff  = '0;
			seg_slope = 4'd0;
			seg_base  = '0;
		end else if (lvl_ext < T60) begin
			seg_diff  = DW'(lvl_ext + P70);
			seg_slope = 4'd1;
			seg_base  = '0;
		end else if (lvl_ext < T50) begin
			seg_diff  = DW'(lvl_ext + P60);
			seg_slope = 4'd2;
			seg_base  = DEF_W'(10 * S);
		end else if (lvl_ext < T40) begin
			seg_diff  = DW'(lvl_ext + P50);
			seg_slope = 4'd3;
			seg_base  = DEF_W'(30 * S);
		end else if (lvl_ext < T30) begin
			seg_diff  = DW'(lvl_ext + P40);
			seg_slope = 4'd6;
			seg_base  = DEF_W'(60 * S);
		end else if (lvl_ext < T20) begin
			seg_diff  = DW'(lvl_ext + P30);
			seg_slope = 4'd8;
			seg_base  = DEF_W'(120 * S);
		end else if (lvl_ext < 0) begin
			seg_diff  = DW'(lvl_ext + P20);
			seg_slope = 4'd10;
			seg_base  = DEF_W'(200 * S);
		end else begin
			seg_diff  = '0;
			seg_slope = 4'd0;
			seg_base  = DEF_W'(400 * S);
		end
	end

	assign prod = PW'(mul_a) * PW'(mul_b);

	// next state
	always_comb begin
		state_d = state_q;
		unique case (state_q)
			iecm_pkg::ST_IDLE:  if (in_valid) state_d = iecm_pkg::ST_SEG;
			iecm_pkg::ST_SEG:   state_d = iecm_pkg::ST_SCALE;
			iecm_pkg::ST_SCALE: state_d = iecm_pkg::ST_RECIP;
			iecm_pkg::ST_RECIP: state_d = iecm_pkg::ST_UPD;
			iecm_pkg::ST_UPD:   if (commit) state_d = iecm_pkg::ST_IDLE;
			default:            state_d = iecm_pkg::ST_IDLE;
		endcase
	end

	// sequencer outputs: multiplier operands and handshake
	always_comb begin
		mul_a    = '0;
		mul_b    = '0;
		in_ready = 1'b0;
		commit   = 1'b0;
		unique case (state_q)
			iecm_pkg::ST_IDLE: begin
				in_ready = 1'b1;
			end
			iecm_pkg::ST_SEG: begin
				mul_a = DEF_W'(seg_diff);
				mul_b = 16'(seg_slope);
			end
			iecm_pkg::ST_SCALE: begin
				mul_a = def_q;
				mul_b = 16'(display_width_q);
			end
			iecm_pkg::ST_RECIP: begin
				mul_a = DEF_W'(scaled_q);
				mul_b = iecm_pkg::RECIP_25;
			end
			iecm_pkg::ST_UPD: begin
				commit = !out_valid_q || out_ready;
			end
			default: begin
				in_ready = 1'b0;
			end
		endcase
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= iecm_pkg::ST_IDLE;
		end else begin
			state_q <= state_d;
		end
	end

	// datapath registers
	always_ff @(posedge clk) begin
		if (in_valid && in_ready) begin
			lvl_q <= level_db;
		end
		if (state_q == iecm_pkg::ST_SEG) begin
			def_q <= DEF_W'(prod) + seg_base;
		end
		// divide by 400 * 2^F: shift out 16 * 2^F here, divide by 25 next
		if (state_q == iecm_pkg::ST_SCALE) begin
			scaled_q <= prod[F+4 +: iecm_pkg::QW];
		end
		if (state_q == iecm_pkg::ST_RECIP) begin
			bar_q <= prod[iecm_pkg::RECIP_SH +: 8];
		end
		if (commit) begin
			bar_length_q <= bar_q;
		end
	end

	// peak hold and output valid
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			held_peak_q    <= '0;
			hold_counter_q <= '0;
			out_valid_q    <= 1'b0;
		end else begin
			if (commit) begin
				out_valid_q <= 1'b1;
				if (bar_q > held_peak_q) begin
					held_peak_q    <= bar_q;
					hold_counter_q <= '0;
				end else begin
					if (hold_counter_q < iecm_pkg::COUNTER_MAX) begin
						hold_counter_q <= hold_counter_q + 9'd1;
					end
					// old count past the limit: marker falls to the bar
					if (hold_counter_q > {1'b0, hold_limit_q}) begin
						held_peak_q <= bar_q;
					end
				end
			end else if (out_ready) begin
				out_valid_q <= 1'b0;
			end
		end
	end

	assign out_valid   = out_valid_q;
	assign bar_length  = bar_length_q;
	assign peak_marker = held_peak_q;

endmodule

/* dv/tb_top.sv */
`timescale 1ns / 100ps

module tb_top;

	localparam int FRAC     = iecm_pkg::LEVEL_FRAC_BITS_DEF;
	localparam int WD_LIMIT = 5000;

	typedef struct packed {
		logic [7:0] bar;
		logic [7:0] mark;
	} meter_res_t;

	logic               clk       = 1'b0;
	logic               arst_n    = 1'b0;
	logic               in_valid  = 1'b0;
	logic               in_ready;
	logic signed [15:0] level_db  = '0;
	logic               out_valid;
	logic               out_ready = 1'b0;
	logic        [7:0]  bar_length;
	logic        [7:0]  peak_marker;
	logic               psel      = 1'b0;
	logic               penable   = 1'b0;
	logic               pwrite    = 1'b0;
	logic        [2:0]  paddr     = '0;
	logic        [31:0] pwdata    = '0;
	logic        [31:0] prdata;
	logic               pready;

	// shadow of the block's registers and peak-hold state
	logic [7:0]  cfg_width = iecm_pkg::DISPLAY_WIDTH_RST;
	logic [7:0]  cfg_hold  = iecm_pkg::HOLD_LIMIT_RST;
	logic [7:0]  held_mark = '0;
	logic [8:0]  hold_cnt  = '0;

	logic signed [15:0] level_q[$];
	meter_res_t         want_q[$];
	meter_res_t         got;

	logic hold_off = 1'b0;
	int   idle_pct = 10;
	int   n_err    = 0;
	int   n_levels = 0;
	int   n_results = 0;
	int   n_cfg    = 0;
	int   wd_cnt   = 0;

	iec_meter_scale_peak_hold #(
		.LEVEL_FRAC_BITS(FRAC)
	) u_dut (
		.clk(clk),
		.arst_n(arst_n),
		.in_valid(in_valid),
		.in_ready(in_ready),
		.level_db(level_db),
		.out_valid(out_valid),
		.out_ready(out_ready),
		.bar_length(bar_length),
		.peak_marker(peak_marker),
		.psel(psel),
		.penable(penable),
		.pwrite(pwrite),
		.paddr(paddr),
		.pwdata(pwdata),
		.prdata(prdata),
		.pready(pready)
	);

	always #6 clk = ~clk;

	// deflection curve, width scaling and peak hold for one level
	function automatic meter_res_t meter_update(input logic signed [15:0] lvl_in);
		longint     s;
		longint     lvl;
		longint     defl;
		longint     barv;
		logic [8:0] old_cnt;
		meter_res_t r;
		s   = longint'(1) << FRAC;
		lvl = lvl_in;
		if (lvl < -70 * s) begin
			defl = 0;
		end else if (lvl < -60 * s) begin
			defl = lvl + 70 * s;
		end else if (lvl < -50 * s) begin
			defl = (lvl + 60 * s) * 2 + 10 * s;
		end else if (lvl < -40 * s) begin
			defl = (lvl + 50 * s) * 3 + 30 * s;
		end else if (lvl < -30 * s) begin
			defl = (lvl + 40 * s) * 6 + 60 * s;
		end else if (lvl < -20 * s) begin
			defl = (lvl + 30 * s) * 8 + 120 * s;
		end else if (lvl < 0) begin
			defl = (lvl + 20 * s) * 10 + 200 * s;
		end else begin
			defl = 400 * s;
		end
		barv = (defl * longint'(cfg_width)) / (400 * s);
		if (barv > 255)
			barv = 255;
		if (barv[7:0] > held_mark) begin
			held_mark = barv[7:0];
			hold_cnt  = '0;
		end else begin
			old_cnt = hold_cnt;
			if (hold_cnt < iecm_pkg::COUNTER_MAX)
				hold_cnt = hold_cnt + 9'd1;
			if (old_cnt > {1'b0, cfg_hold})
				held_mark = barv[7:0];
		end
		r.bar  = barv[7:0];
		r.mark = held_mark;
		return r;
	endfunction

	function automatic logic signed [15:0] pick_level();
		int m;
		int v;
		m = $urandom_range(99);
		if (m < 12) begin
			v = int'($urandom_range(65535)) - 32768;
		end else if (m < 30) begin
			// near a multiple of 10 dB down to -70 dB, which includes every segment boundary
			v = -256 * 10 * int'($urandom_range(7)) + int'($urandom_range(8)) - 4;
		end else begin
			v = int'($urandom_range(73 * 256)) - 72 * 256;
		end
		return 16'(v);
	endfunction

	task automatic push_random(input int n);
		int k;
		int run;
		int step;
		int v;
		k = 0;
		while (k < n) begin
			if ($urandom_range(5) == 0) begin
				// loud hit then a slow decay, exercises hold and fall
				run  = $urandom_range(30, 5);
				step = $urandom_range(400, 20);
				v    = int'($urandom_range(20 * 256)) - 20 * 256;
				repeat (run) begin
					level_q.push_back(16'(v));
					v = v - step;
					if (v < -75 * 256)
						v = -75 * 256;
				end
				k = k + run;
			end else begin
				level_q.push_back(pick_level());
				k = k + 1;
			end
		end
	endtask

	task automatic drain();
		while (level_q.size() != 0 || in_valid || want_q.size() != 0)
			@(posedge clk);
		repeat (8) @(posedge clk);
	endtask

	task automatic reg_write(input logic [2:0] addr, input logic [7:0] val);
		@(posedge clk);
		psel    <= 1'b1;
		penable <= 1'b0;
		pwrite  <= 1'b1;
		paddr   <= addr;
		pwdata  <= ($urandom() & 32'hFFFF_FF00) | {24'h0, val};
		@(posedge clk);
		penable <= 1'b1;
		do @(posedge clk); while (!pready);
		psel    <= 1'b0;
		penable <= 1'b0;
		pwrite  <= 1'b0;
		if (addr == iecm_pkg::ADDR_DISPLAY_WIDTH)
			cfg_width = val;
		else if (addr == iecm_pkg::ADDR_HOLD_LIMIT)
			cfg_hold = val;
		n_cfg++;
	endtask

	task automatic reg_check(input logic [2:0] addr, input logic [7:0] val);
		@(posedge clk);
		psel    <= 1'b1;
		penable <= 1'b0;
		pwrite  <= 1'b0;
		paddr   <= addr;
		@(posedge clk);
		penable <= 1'b1;
		do @(posedge clk); while (!pready);
		if (prdata[7:0] !== val) begin
			n_err++;
			$display("%0t: readback addr %0d expected %0d actual %0d",
				$time, addr, val, prdata[7:0]);
		end
		psel    <= 1'b0;
		penable <= 1'b0;
	endtask

	task automatic set_meter(input logic [7:0] width, input logic [7:0] hold);
		drain();
		reg_write(iecm_pkg::ADDR_DISPLAY_WIDTH, width);
		reg_write(iecm_pkg::ADDR_HOLD_LIMIT, hold);
		reg_check(iecm_pkg::ADDR_DISPLAY_WIDTH, width);
		reg_check(iecm_pkg::ADDR_HOLD_LIMIT, hold);
	endtask

	// request driver; predicts at the accepting edge
	always @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			in_valid  <= 1'b0;
			level_db  <= '0;
			out_ready <= 1'b0;
		end else begin
			if (in_valid && in_ready) begin
				want_q.push_back(meter_update(level_db));
				n_levels++;
			end
			if (!in_valid || in_ready) begin
				if (level_q.size() != 0 && !hold_off && $urandom_range(99) >= idle_pct) begin
					in_valid <= 1'b1;
					level_db <= level_q.pop_front();
				end else begin
					in_valid <= 1'b0;
				end
			end
			out_ready <= ($urandom_range(99) >= idle_pct);
		end
	end

	// result monitor
	always @(posedge clk) begin
		if (arst_n && out_valid && out_ready) begin
			n_results++;
			if (want_q.size() == 0) begin
				n_err++;
				$display("%0t: unexpected result bar %0d marker %0d",
					$time, bar_length, peak_marker);
			end else begin
				got = want_q.pop_front();
				if (bar_length !== got.bar) begin
					n_err++;
					$display("%0t: bar_length expected %0d actual %0d",
						$time, got.bar, bar_length);
				end
				if (peak_marker !== got.mark) begin
					n_err++;
					$display("%0t: peak_marker expected %0d actual %0d",
						$time, got.mark, peak_marker);
				end
			end
		end
	end

	always @(posedge clk) begin
		if (arst_n) begin
			if ((in_valid && in_ready) || (out_valid && out_ready) || psel)
				wd_cnt = 0;
			else
				wd_cnt = wd_cnt + 1;
			if (wd_cnt >= WD_LIMIT) begin
				$display("%0t: no progress for %0d cycles", $time, WD_LIMIT);
				$display("tb_top: done, errors");
				$finish;
			end
		end
	end

	initial begin
		repeat (12) @(posedge clk);
		arst_n <= 1'b1;
		repeat (2) @(posedge clk);

		// reset values, then segment edges and range extremes
		reg_check(iecm_pkg::ADDR_DISPLAY_WIDTH, iecm_pkg::DISPLAY_WIDTH_RST);
		reg_check(iecm_pkg::ADDR_HOLD_LIMIT, iecm_pkg::HOLD_LIMIT_RST);
		level_q.push_back(16'sh8000);
		level_q.push_back(16'sh7fff);
		level_q.push_back(16'sd0);
		level_q.push_back(-16'sd1);
		level_q.push_back(16'(-70 * 256 - 1));
		level_q.push_back(16'(-70 * 256));
		level_q.push_back(16'(-70 * 256 + 1));
		level_q.push_back(16'(-60 * 256 - 1));
		level_q.push_back(16'(-60 * 256));
		level_q.push_back(16'(-50 * 256));
		level_q.push_back(16'(-40 * 256 - 1));
		level_q.push_back(16'(-40 * 256));
		level_q.push_back(16'(-30 * 256));
		level_q.push_back(16'(-20 * 256 - 1));
		level_q.push_back(16'(-20 * 256));
		level_q.push_back(16'(-10 * 256));
		push_random(40);

		// widest meter, no hold, no idling
		set_meter(8'd255, 8'd0);
		idle_pct <= 0;
		push_random(40);
		drain();
		idle_pct <= 10;

		// zero width: bar stays at zero
		set_meter(8'd0, 8'd3);
		push_random(30);

		// one cell, longest hold, sender pauses mid phase
		set_meter(8'd1, 8'd255);
		push_random(20);
		while (level_q.size() != 0)
			@(posedge clk);
		hold_off <= 1'b1;
		while (in_valid || want_q.size() != 0)
			@(posedge clk);
		repeat (3) @(posedge clk);
		hold_off <= 1'b0;
		push_random(20);

		set_meter(8'd128, 8'd1);
		push_random(30);

		// hold counter saturation: full scale, then a long flat stretch, then falling
		set_meter(8'd255, 8'd255);
		level_q.push_back(16'sd0);
		repeat (515) level_q.push_back(16'(-3 * 256));
		for (int i = 0; i < 20; i++)
			level_q.push_back(16'(-10 * 256 - i * 300));

		set_meter(8'd200, 8'd7);
		push_random(30);

		drain();
		repeat (20) @(posedge clk);
		$display("covered %0d levels and %0d results over %0d register writes,",
			n_levels, n_results, n_cfg);
		$display("incl. zero and full width, zero and max hold, counter saturation");
		if (n_err == 0 && want_q.size() == 0) begin
			$display("tb_top: done, clean");
		end else begin
			$display("tb_top: done, errors");
		end
		$finish;
	end

endmodule
